@@ hw/rtl/cvrl_pkg.sv @@
// Shared types and codes for the circular record log.
package cvrl_pkg;

    typedef enum logic [2:0] {
        REQ_APPEND  = 3'd0,
        REQ_DATA    = 3'd1,
        REQ_RESTART = 3'd2,
        REQ_NEXT    = 3'd3,
        REQ_READ    = 3'd4,
        REQ_FLUSH   = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OFFSET    = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_MORE   = 3'd3,
        ST_STRAY     = 3'd4
    } status_t;

    localparam int LEN_W  = 12;
    localparam int SIZE_W = 13;

endpackage

@@ hw/rtl/circular_variable_record_log_unit.sv @@
// Top level of the circular variable-length record log.
// A read fetches the record header, then the requested byte when it returns one; an iterator
// next on an unwrapped walk fetches the last record's header before the current one; an append
// into a non-empty log fetches the newest header and walks record headers during eviction.
// One memory port is shared by all accesses.
// busy stays high until the strobe cycle; the next item can be accepted as the strobe ends.
// Reset (rst_n low, asynchronous) empties the log; log bytes are undefined.
module circular_variable_record_log_unit #(
    parameter int BUF_BYTES = 4096,
    parameter int HDR_BYTES = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             req_type,
    input  logic [11:0]            length,
    input  logic [7:0]             data_byte,
    input  logic [11:0]            entry_addr,
    input  logic [11:0]            byte_offset,
    output logic                   done,
    output logic [2:0]             status,
    output logic [11:0]            read_count,
    output logic [7:0]             read_byte,
    output logic [11:0]            record_addr,
    output logic [11:0]            record_length,
    output logic                   found,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [12:0]            cfg_data
);
    import cvrl_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);
    localparam int XW = 18;

    typedef enum logic [3:0] {
        S_IDLE, S_HDR0, S_HDR1, S_HDR2, S_HDRW, S_SEQ, S_EVCHK, S_WRH, S_DONE
    } state_t;

    // Purpose of a header fetch
    typedef enum logic [2:0] {
        F_NEWEST, F_OLDEST, F_EVICT, F_ITER, F_ITERL, F_READ, F_RBYTE
    } fetch_t;

    state_t state_reg;
    fetch_t fetch_reg;
    logic [12:0] log_size_reg;
    logic [11:0] oldest_reg, newest_reg, wptr_reg, left_reg;
    logic oldest_v_reg, newest_v_reg;
    logic [12:0] wrap_reg;
    logic [11:0] icur_reg, ifirst_reg, ilast_reg;
    logic ivalid_reg;
    logic [2:0] req_reg;
    logic [11:0] len_reg, eaddr_reg, boff_reg;
    logic [7:0] dbyte_reg;
    logic [XW-1:0] addr_reg;
    logic [7:0] lo_reg;
    logic [XW-1:0] dst_reg, end_reg, evs_reg;
    logic [3:0] hcnt_reg;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0] ram_wdata, ram_rdata;
    logic addr_ok;
    logic [7:0] rd_val;
    logic [11:0] fetched;
    logic [XW-1:0] esz, nxt, hdr_base;

    assign esz = (log_size_reg > 13'(BUF_BYTES)) ? XW'(BUF_BYTES) :
                 (log_size_reg < 13'd64) ? XW'(64) : XW'(log_size_reg);
    assign addr_ok = addr_reg < XW'(BUF_BYTES);
    assign rd_val = addr_ok ? ram_rdata : 8'd0;
    assign fetched = (HDR_BYTES >= 2) ? {rd_val[3:0], lo_reg} : {4'd0, lo_reg};
    assign hdr_base = addr_reg - XW'((HDR_BYTES >= 2) ? 1 : 0);
    assign nxt = hdr_base + XW'(HDR_BYTES) + XW'(fetched);

    cvrl_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // Memory port drive
    always_comb
    begin
        ram_we = 1'b0;
        ram_wdata = dbyte_reg;
        ram_addr = addr_reg[AW-1:0];
        if (state_reg == S_WRH)
        begin
            ram_we = addr_ok;
            ram_wdata = (hcnt_reg == 4'd0) ? len_reg[7:0] :
                        (hcnt_reg == 4'd1) ? {4'd0, len_reg[11:8]} : 8'd0;
        end
        else if (state_reg == S_SEQ && req_reg == REQ_DATA)
        begin
            ram_we = addr_ok && (left_reg != 12'd0);
        end
    end

    // Sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fetch_reg <= F_NEWEST;
            log_size_reg <= 13'd4096;
            oldest_reg <= '0; newest_reg <= '0; oldest_v_reg <= 1'b0;
            newest_v_reg <= 1'b0; wrap_reg <= '0; wptr_reg <= '0; left_reg <= '0;
            icur_reg <= '0; ifirst_reg <= '0; ilast_reg <= '0; ivalid_reg <= 1'b0;
            done <= 1'b0; status <= ST_OK; read_count <= '0; read_byte <= '0;
            record_addr <= '0; record_length <= '0; found <= 1'b0;
            req_reg <= '0; len_reg <= '0; eaddr_reg <= '0; boff_reg <= '0;
            dbyte_reg <= '0; addr_reg <= '0; lo_reg <= '0; dst_reg <= '0;
            end_reg <= '0; evs_reg <= '0; hcnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        log_size_reg <= cfg_data;
                    end
                    if (start)
                    begin
                        req_reg <= req_type; len_reg <= length; dbyte_reg <= data_byte;
                        eaddr_reg <= entry_addr; boff_reg <= byte_offset;
                        addr_reg <= XW'(wptr_reg);
                        status <= ST_OK; read_count <= '0; read_byte <= '0;
                        record_addr <= '0; record_length <= '0; found <= 1'b0;
                        state_reg <= S_SEQ;
                    end
                end
                // Dispatch the held item
                S_SEQ:
                begin
                    state_reg <= S_DONE;
                    case (req_reg)
                        REQ_APPEND:
                        begin
                            if (XW'(HDR_BYTES) + XW'(len_reg) > esz ||
                                (HDR_BYTES < 2 && len_reg > 12'd255))
                            begin
                                status <= ST_TOO_LARGE;
                            end
                            else if (newest_v_reg)
                            begin
                                fetch_reg <= F_NEWEST;
                                addr_reg <= XW'(newest_reg);
                                state_reg <= S_HDR0;
                            end
                            else
                            begin
                                dst_reg <= '0;
                                state_reg <= S_EVCHK;
                                evs_reg <= '1;
                            end
                        end
                        REQ_DATA:
                        begin
                            if (left_reg == 12'd0)
                            begin
                                status <= ST_STRAY;
                            end
                            else
                            begin
                                wptr_reg <= wptr_reg + 12'd1;
                                left_reg <= left_reg - 12'd1;
                            end
                        end
                        REQ_RESTART:
                        begin
                            ifirst_reg <= oldest_reg; icur_reg <= oldest_reg;
                            ilast_reg <= newest_reg; ivalid_reg <= oldest_v_reg;
                        end
                        REQ_NEXT:
                        begin
                            if (!ivalid_reg)
                            begin
                                status <= ST_NO_MORE;
                            end
                            else if (ifirst_reg > ilast_reg)
                            begin
                                fetch_reg <= F_ITER;
                                addr_reg <= XW'(icur_reg);
                                state_reg <= S_HDR0;
                            end
                            else
                            begin
                                fetch_reg <= F_ITERL;
                                addr_reg <= XW'(ilast_reg);
                                state_reg <= S_HDR0;
                            end
                        end
                        REQ_READ:
                        begin
                            fetch_reg <= F_READ;
                            addr_reg <= XW'(eaddr_reg);
                            state_reg <= S_HDR0;
                        end
                        REQ_FLUSH:
                        begin
                            oldest_reg <= '0; oldest_v_reg <= 1'b0; newest_reg <= '0;
                            newest_v_reg <= 1'b0; wrap_reg <= '0; left_reg <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                // Low header byte arrives next cycle
                S_HDR0:
                begin
                    state_reg <= S_HDR1;
                end
                S_HDR1:
                begin
                    lo_reg <= rd_val;
                    if (fetch_reg == F_RBYTE)
                    begin
                        read_byte <= rd_val;
                        state_reg <= S_DONE;
                    end
                    else if (HDR_BYTES >= 2)
                    begin
                        addr_reg <= addr_reg + XW'(1);
                        state_reg <= S_HDR2;
                    end
                    else
                    begin
                        addr_reg <= addr_reg;
                        state_reg <= S_HDRW;
                    end
                end
                // Wait for the high header byte
                S_HDR2:
                begin
                    state_reg <= S_HDRW;
                end
                // Header complete: act on it
                S_HDRW:
                begin
                    state_reg <= S_DONE;
                    case (fetch_reg)
                        F_NEWEST:
                        begin
                            dst_reg <= nxt;
                            evs_reg <= '1;
                            state_reg <= S_EVCHK;
                        end
                        F_OLDEST, F_EVICT:
                        begin
                            if (fetch_reg == F_OLDEST &&
                                !(dst_reg < nxt && end_reg > hdr_base))
                            begin
                                state_reg <= S_WRH;
                                addr_reg <= dst_reg; hcnt_reg <= '0;
                            end
                            else if (nxt == XW'(wrap_reg))
                            begin
                                oldest_reg <= '0;
                                state_reg <= S_WRH;
                                addr_reg <= dst_reg; hcnt_reg <= '0;
                            end
                            else if (nxt < end_reg)
                            begin
                                fetch_reg <= F_EVICT;
                                addr_reg <= nxt;
                                state_reg <= S_HDR0;
                            end
                            else
                            begin
                                oldest_reg <= nxt[11:0];
                                state_reg <= S_WRH;
                                addr_reg <= dst_reg; hcnt_reg <= '0;
                            end
                        end
                        F_ITERL:
                        begin
                            if (XW'(icur_reg) == nxt)
                            begin
                                status <= ST_NO_MORE;
                            end
                            else
                            begin
                                fetch_reg <= F_ITER;
                                addr_reg <= XW'(icur_reg);
                                state_reg <= S_HDR0;
                            end
                        end
                        F_ITER:
                        begin
                            record_addr <= icur_reg; record_length <= fetched;
                            found <= 1'b1;
                            if (ifirst_reg > ilast_reg && nxt >= XW'(wrap_reg))
                            begin
                                icur_reg <= '0; ifirst_reg <= '0;
                            end
                            else
                            begin
                                icur_reg <= nxt[11:0];
                            end
                        end
                        F_READ:
                        begin
                            if (boff_reg > fetched)
                            begin
                                status <= ST_OFFSET;
                            end
                            else
                            begin
                                if (XW'(boff_reg) + XW'(len_reg) > XW'(fetched))
                                begin
                                    read_count <= fetched - boff_reg;
                                end
                                else
                                begin
                                    read_count <= len_reg;
                                end
                                if (len_reg != 12'd0 && boff_reg != fetched)
                                begin
                                    fetch_reg <= F_RBYTE;
                                    addr_reg <= XW'(eaddr_reg) + XW'(HDR_BYTES) +
                                                XW'(boff_reg);
                                    state_reg <= S_HDR0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                // Place record, handle wrap, start eviction check
                S_EVCHK:
                begin
                    if (evs_reg != '0)
                    begin
                        evs_reg <= '0;
                        if (dst_reg + XW'(HDR_BYTES) + XW'(len_reg) > esz)
                        begin
                            wrap_reg <= dst_reg[12:0];
                            dst_reg <= '0;
                            end_reg <= XW'(HDR_BYTES) + XW'(len_reg);
                            if (oldest_v_reg && {1'b0, oldest_reg} >= dst_reg[12:0])
                            begin
                                oldest_reg <= '0;
                            end
                        end
                        else
                        begin
                            end_reg <= dst_reg + XW'(HDR_BYTES) + XW'(len_reg);
                        end
                    end
                    else if (oldest_v_reg)
                    begin
                        fetch_reg <= F_OLDEST;
                        addr_reg <= XW'(oldest_reg);
                        state_reg <= S_HDR0;
                    end
                    else
                    begin
                        addr_reg <= dst_reg; hcnt_reg <= '0;
                        state_reg <= S_WRH;
                    end
                end
                // Write header bytes, then commit the record
                S_WRH:
                begin
                    if (hcnt_reg == 4'(HDR_BYTES - 1))
                    begin
                        newest_reg <= dst_reg[11:0]; newest_v_reg <= 1'b1;
                        if (!oldest_v_reg)
                        begin
                            oldest_reg <= dst_reg[11:0]; oldest_v_reg <= 1'b1;
                        end
                        wptr_reg <= dst_reg[11:0] + 12'(HDR_BYTES);
                        left_reg <= len_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        hcnt_reg <= hcnt_reg + 4'd1;
                        addr_reg <= addr_reg + XW'(1);
                    end
                end
                S_DONE:
                begin
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/cvrl_ram.sv @@
// Generic single-port RAM with registered read.
module cvrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read one entry per cycle, and write it as well when we is set
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/cvrl_checker.sv @@
// Port-level checks for the circular record log.
module cvrl_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic found,
    input logic [2:0] status,
    input logic cfg_ready
);
    import cvrl_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy during result");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> status == ST_OK) else $error("found with error");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy) else $error("config while busy");

endmodule

bind circular_variable_record_log_unit cvrl_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .found(found), .status(status), .cfg_ready(cfg_ready)
);

@@ test/circular_variable_record_log_unit_test.sv @@
// Self-checking testbench for the circular variable-length record log unit.
`timescale 1ns / 100ps

module circular_variable_record_log_unit_test;
    import cvrl_pkg::*;

    localparam int MEM_BYTES = 4096;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [2:0]  req;
        logic [11:0] len;
        logic [7:0]  dbyte;
        logic [11:0] eaddr;
        logic [11:0] boff;
    } log_item_t;

    typedef struct {
        status_t     st;
        logic [11:0] rcount;
        logic [7:0]  rbyte;
        logic [11:0] raddr;
        logic [11:0] rlen;
        logic        hit;
    } log_answer_t;

    typedef struct {
        logic [7:0]  mem [MEM_BYTES];
        bit          known [MEM_BYTES];
        int unsigned size_reg;
        int unsigned oldest;
        bit          oldest_ok;
        int unsigned newest;
        bit          newest_ok;
        int unsigned wrap_at;
        int unsigned wr_ptr;
        int unsigned left;
        int unsigned it_cur;
        int unsigned it_first;
        int unsigned it_last;
        bit          it_ok;
    } log_shadow_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [11:0] length;
    logic [7:0]  data_byte;
    logic [11:0] entry_addr;
    logic [11:0] byte_offset;
    logic        done;
    logic [2:0]  status;
    logic [11:0] read_count;
    logic [7:0]  read_byte;
    logic [11:0] record_addr;
    logic [11:0] record_length;
    logic        found;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;

    log_shadow_t lg;
    log_shadow_t saved;
    bit          touched_unknown;
    log_item_t   pending_items [$];
    log_answer_t expected_answers [$];
    int unsigned header_addrs [$];
    int          idle_pct;
    int          errors;
    int          cycles;
    bit          drive_on;

    circular_variable_record_log_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .length(length), .data_byte(data_byte),
        .entry_addr(entry_addr), .byte_offset(byte_offset),
        .done(done), .status(status), .read_count(read_count),
        .read_byte(read_byte), .record_addr(record_addr),
        .record_length(record_length), .found(found),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------- log predictor ----------------

    function automatic int unsigned peek_byte(int unsigned a);
        if (a >= MEM_BYTES)
            return 0;
        if (!lg.known[a])
            touched_unknown = 1'b1;
        return lg.mem[a];
    endfunction

    function automatic void poke_byte(int unsigned a, int unsigned v);
        if (a < MEM_BYTES)
        begin
            lg.mem[a] = v[7:0];
            lg.known[a] = 1'b1;
        end
    endfunction

    function automatic int unsigned hdr_len(int unsigned a);
        return (peek_byte(a) | (peek_byte(a + 1) << 8)) & 12'hFFF;
    endfunction

    function automatic int unsigned next_hdr(int unsigned a);
        return a + 2 + hdr_len(a);
    endfunction

    function automatic int unsigned used_size();
        int unsigned s;
        s = lg.size_reg;
        if (s > MEM_BYTES)
            s = MEM_BYTES;
        if (s < 64)
            s = 64;
        return s;
    endfunction

    function automatic status_t open_record(int unsigned len);
        int unsigned dst;
        int unsigned stop_at;
        int unsigned walk;
        int          guard;
        if (2 + len > used_size())
            return ST_TOO_LARGE;
        dst = lg.newest_ok ? next_hdr(lg.newest) : 0;
        stop_at = dst + 2 + len;
        if (stop_at > used_size())
        begin
            lg.wrap_at = dst & 13'h1FFF;
            dst = 0;
            stop_at = 2 + len;
            if (lg.oldest_ok && lg.oldest >= lg.wrap_at)
                lg.oldest = 0;
        end
        // evict oldest records that the new one overlaps
        if (lg.oldest_ok)
        begin
            walk = lg.oldest;
            if (dst < walk + 2 + hdr_len(walk) && stop_at > walk)
            begin
                guard = 0;
                while (walk < stop_at)
                begin
                    walk = next_hdr(walk);
                    guard++;
                    if (walk == lg.wrap_at)
                    begin
                        walk = 0;
                        break;
                    end
                    if (guard > 5000)
                    begin
                        touched_unknown = 1'b1;
                        break;
                    end
                end
                lg.oldest = walk & 12'hFFF;
            end
        end
        poke_byte(dst, len & 8'hFF);
        poke_byte(dst + 1, len >> 8);
        lg.newest = dst;
        lg.newest_ok = 1'b1;
        if (!lg.oldest_ok)
        begin
            lg.oldest = dst;
            lg.oldest_ok = 1'b1;
        end
        lg.wr_ptr = (dst + 2) & 12'hFFF;
        lg.left = len;
        return ST_OK;
    endfunction

    function automatic log_answer_t predict_log(log_item_t it);
        log_answer_t r;
        int unsigned h;
        int unsigned l;
        r = '{ST_OK, 0, 0, 0, 0, 0};
        case (it.req)
            REQ_APPEND:
                r.st = open_record(it.len);
            REQ_DATA:
                if (lg.left == 0)
                    r.st = ST_STRAY;
                else
                begin
                    poke_byte(lg.wr_ptr, it.dbyte);
                    lg.wr_ptr = (lg.wr_ptr + 1) & 12'hFFF;
                    lg.left--;
                end
            REQ_RESTART:
            begin
                lg.it_first = lg.oldest;
                lg.it_cur = lg.oldest;
                lg.it_last = lg.newest;
                lg.it_ok = lg.oldest_ok;
            end
            REQ_NEXT:
                if (!lg.it_ok)
                    r.st = ST_NO_MORE;
                else if (lg.it_first > lg.it_last)
                begin
                    h = lg.it_cur;
                    lg.it_cur = next_hdr(lg.it_cur);
                    if (lg.it_cur >= lg.wrap_at)
                    begin
                        lg.it_cur = 0;
                        lg.it_first = 0;
                    end
                    lg.it_cur &= 12'hFFF;
                    r.raddr = h;
                    r.rlen = hdr_len(h);
                    r.hit = 1'b1;
                end
                else
                begin
                    h = lg.it_cur;
                    if (h == next_hdr(lg.it_last))
                        r.st = ST_NO_MORE;
                    else
                    begin
                        lg.it_cur = next_hdr(lg.it_cur) & 12'hFFF;
                        r.raddr = h;
                        r.rlen = hdr_len(h);
                        r.hit = 1'b1;
                    end
                end
            REQ_READ:
            begin
                l = hdr_len(it.eaddr);
                if (it.boff > l)
                    r.st = ST_OFFSET;
                else
                begin
                    h = it.len;
                    if (it.boff + it.len > l)
                        h = l - it.boff;
                    r.rcount = h;
                    if (h != 0)
                        r.rbyte = peek_byte(it.eaddr + 2 + it.boff);
                end
            end
            REQ_FLUSH:
            begin
                lg.oldest = 0;
                lg.oldest_ok = 1'b0;
                lg.newest = 0;
                lg.newest_ok = 1'b0;
                lg.wrap_at = 0;
                lg.left = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Predict an item; one that would touch never-written log bytes becomes a restart.
    task automatic queue_item(logic [2:0] req, int unsigned len, int unsigned db,
                              int unsigned ea, int unsigned bo);
        log_item_t   it;
        log_answer_t r;
        it = '{req, len[11:0], db[7:0], ea[11:0], bo[11:0]};
        saved = lg;
        touched_unknown = 1'b0;
        r = predict_log(it);
        if (touched_unknown)
        begin
            lg = saved;
            it.req = REQ_RESTART;
            r = predict_log(it);
        end
        else if (req == REQ_APPEND && r.st == ST_OK)
            header_addrs.push_back(lg.newest);
        pending_items.push_back(it);
        expected_answers.push_back(r);
    endtask

    function automatic int unsigned pick_header();
        if (header_addrs.size() == 0)
            return 0;
        return header_addrs[$urandom_range(0, header_addrs.size() - 1)];
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        log_item_t nxt;
        logic      go;
        if (!rst_n)
        begin
            start <= 1'b0;
            req_type <= REQ_RESTART;
            length <= '0;
            data_byte <= '0;
            entry_addr <= '0;
            byte_offset <= '0;
        end
        else
        begin
            go = start;
            if (start && !busy)
            begin
                void'(pending_items.pop_front());
                go = 1'b0;
            end
            if (!go && drive_on && pending_items.size() > 0 &&
                $urandom_range(0, 99) >= idle_pct)
            begin
                nxt = pending_items[0];
                go = 1'b1;
                req_type <= nxt.req;
                length <= nxt.len;
                data_byte <= nxt.dbyte;
                entry_addr <= nxt.eaddr;
                byte_offset <= nxt.boff;
            end
            start <= go;
        end
    end

    // ---------------- monitor ----------------

    task automatic compare_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        log_answer_t e;
        if (rst_n)
        begin
            cycles++;
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result strobe with no item outstanding");
                    errors++;
                end
                else
                begin
                    e = expected_answers.pop_front();
                    compare_field("status", e.st, status);
                    compare_field("read_count", e.rcount, read_count);
                    compare_field("read_byte", e.rbyte, read_byte);
                    compare_field("record_addr", e.raddr, record_addr);
                    compare_field("record_length", e.rlen, record_length);
                    compare_field("found", e.hit, found);
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_answers.size() != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_log_size(int unsigned v);
        cfg_data <= v[12:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        lg.size_reg = v & 13'h1FFF;
    endtask

    task automatic directed_items();
        queue_item(REQ_NEXT, 0, 0, 0, 0);
        queue_item(REQ_DATA, 0, 8'hFF, 0, 0);
        queue_item(REQ_APPEND, 0, 0, 0, 0);
        queue_item(REQ_RESTART, 0, 0, 0, 0);
        queue_item(REQ_NEXT, 0, 0, 0, 0);
        queue_item(REQ_NEXT, 0, 0, 0, 0);
        queue_item(REQ_APPEND, 5, 0, 0, 0);
        queue_item(REQ_DATA, 0, 8'h00, 0, 0);
        queue_item(REQ_DATA, 0, 8'hFF, 0, 0);
        queue_item(REQ_DATA, 0, 8'hA5, 0, 0);
        queue_item(REQ_DATA, 0, 8'h5A, 0, 0);
        queue_item(REQ_DATA, 0, 8'h3C, 0, 0);
        queue_item(REQ_READ, 1, 0, 2, 6);
        queue_item(REQ_READ, 12'hFFF, 0, 2, 0);
        queue_item(REQ_READ, 3, 0, 2, 5);
        queue_item(REQ_READ, 2, 0, 2, 12'hFFF);
        queue_item(REQ_APPEND, 12'hFFF, 0, 0, 0);
        queue_item(REQ_APPEND, 4094, 0, 0, 0);
        queue_item(REQ_APPEND, 3, 0, 0, 0);
        queue_item(REQ_RESTART, 0, 0, 0, 0);
        queue_item(REQ_NEXT, 0, 0, 0, 0);
        queue_item(REQ_FLUSH, 0, 0, 0, 0);
        queue_item(REQ_DATA, 0, 1, 0, 0);
        queue_item(3'd6, 12'hFFF, 8'hFF, 12'hFFF, 12'hFFF);
        queue_item(3'd7, 0, 0, 0, 0);
    endtask

    task automatic random_items(int n);
        int made;
        int pick;
        int len;
        int k;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // well-formed record, sometimes cut short or followed by a stray byte
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(0, used_size() + 8);
                else
                    len = $urandom_range(0, 30);
                if (len > 4095)
                    len = 4095;
                queue_item(REQ_APPEND, len, 0, 0, 0);
                k = len;
                if ($urandom_range(0, 5) == 0)
                    k = $urandom_range(0, len);
                if (k > 40)
                    k = 40;
                repeat (k) queue_item(REQ_DATA, 0, $urandom_range(0, 255), 0, 0);
                if ($urandom_range(0, 5) == 0)
                begin
                    queue_item(REQ_DATA, 0, $urandom_range(0, 255), 0, 0);
                    made++;
                end
                made += 1 + k;
            end
            else if (pick < 60)
            begin
                k = $urandom_range(1, 12);
                queue_item(REQ_RESTART, 0, 0, 0, 0);
                repeat (k) queue_item(REQ_NEXT, 0, 0, 0, 0);
                made += 1 + k;
            end
            else if (pick < 85)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, 20);
                queue_item(REQ_READ, len, $urandom_range(0, 255), pick_header(),
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, 40));
                made++;
            end
            else if (pick < 88)
            begin
                queue_item(REQ_FLUSH, 0, 0, 0, 0);
                made++;
            end
            else if (pick < 93)
            begin
                queue_item(3'($urandom_range(6, 7)), $urandom_range(0, 4095),
                           $urandom_range(0, 255), $urandom_range(0, 4095),
                           $urandom_range(0, 4095));
                made++;
            end
            else
            begin
                queue_item($urandom_range(0, 1) ? REQ_NEXT : REQ_DATA, 0,
                           $urandom_range(0, 255), 0, 0);
                made++;
            end
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        drive_on = 1'b0;
        idle_pct = 37;
        cfg_valid = 1'b0;
        cfg_data = '0;
        lg.size_reg = 4096;
        lg.oldest = 0;
        lg.oldest_ok = 1'b0;
        lg.newest = 0;
        lg.newest_ok = 1'b0;
        lg.wrap_at = 0;
        lg.wr_ptr = 0;
        lg.left = 0;
        lg.it_cur = 0;
        lg.it_first = 0;
        lg.it_last = 0;
        lg.it_ok = 1'b0;
        for (int i = 0; i < MEM_BYTES; i++)
        begin
            lg.mem[i] = '0;
            lg.known[i] = 1'b0;
        end
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-size log, directed then random
        write_log_size(4096);
        directed_items();
        drive_on = 1'b1;
        random_items(300);
        wait_drained();

        // smallest log: heavy wrapping and eviction
        idle_pct = 69;
        write_log_size(64);
        random_items(300);
        wait_drained();

        // register below the floor clamps to the minimum
        idle_pct = 0;
        write_log_size(0);
        random_items(200);
        wait_drained();

        // register above the store clamps to the full size
        write_log_size(13'h1FFF);
        random_items(200);
        wait_drained();

        idle_pct = 37;
        write_log_size($urandom_range(64, 600));
        random_items(225);
        wait_drained();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
